// File: rtl/htfd_pkg.sv
// shared types, constants and helper functions for the humidity/temperature
// frame decoder; no dependencies
package htfd_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int TEMP_W    = 15;
  localparam int HUM_W     = 14;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

  // scale factors, raw full scale is 65535
  localparam int TPROD_W = 31;
  localparam int HPROD_W = 30;
  localparam logic [TPROD_W-1:0] TEMP_SCALE = 31'd17500;
  localparam logic [HPROD_W-1:0] HUM_SCALE  = 30'd10000;
  localparam logic [WORD_W-1:0]  FULL_SCALE = 16'hFFFF;
  localparam logic signed [WORD_W-1:0] TEMP_OFFSET = 16'sd4500;

  localparam logic signed [TEMP_W-1:0] TEMP_LOW_RESET  = -15'sd5000;
  localparam logic signed [TEMP_W-1:0] TEMP_HIGH_RESET = 15'sd13000;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TEMP_CRC = 2'd1,
    STATUS_HUM_CRC  = 2'd2,
    STATUS_RANGE    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    POS_TEMP_HI  = 3'd0,
    POS_TEMP_LO  = 3'd1,
    POS_TEMP_CRC = 3'd2,
    POS_HUM_HI   = 3'd3,
    POS_HUM_LO   = 3'd4,
    POS_HUM_CRC  = 3'd5
  } pos_t;

  // one complete reply as handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] temp_raw;
    logic [WORD_W-1:0] hum_raw;
    logic              temp_crc_ok;
    logic              hum_crc_ok;
  } frame_rec_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] low;
    logic signed [TEMP_W-1:0] high;
  } limits_t;

  function automatic logic [BYTE_W-1:0] crc8_feed(input logic [BYTE_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] c;
    c = crc ^ b;
    for (int i = 0; i < BYTE_W; i++) begin
      c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  // floor(x / 65535) for x below 2^31: estimate x>>16, remainder stays
  // below twice the divisor so one correction step is enough
  function automatic logic [WORD_W-1:0] div_full_scale(input logic [TPROD_W-1:0] x);
    logic [WORD_W-1:0] est;
    logic [WORD_W:0]   rem;
    est = {1'b0, x[TPROD_W-1:WORD_W]};
    rem = {1'b0, x[WORD_W-1:0]} + {1'b0, est};
    if (rem >= {1'b0, FULL_SCALE}) begin
      est = est + 16'd1;
    end
    return est;
  endfunction

endpackage

// File: rtl/htfd_channels.sv
// valid/ready channel interfaces for the frame decoder
// depends on htfd_pkg
interface htfd_byte_if;
  import htfd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;
  modport source (output valid, data_byte, frame_start, input ready);
  modport sink   (input valid, data_byte, frame_start, output ready);
endinterface

interface htfd_result_if;
  import htfd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_centi;
  logic [HUM_W-1:0]         humidity_centi;
  logic [STATUS_W-1:0]      status;
  modport source (output valid, temperature_centi, humidity_centi, status, input ready);
  modport sink   (input valid, temperature_centi, humidity_centi, status, output ready);
endinterface

interface htfd_cfg_if;
  import htfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [TEMP_W-1:0]    write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// File: rtl/htfd_front.sv
// front end: takes reply bytes, tracks byte position, runs the crc and
// assembles one frame record per reply; depends on htfd_pkg, htfd_channels
module htfd_front (
  input  logic                clk,
  input  logic                rst,
  htfd_byte_if.sink           byte_in,
  input  logic                queue_full,
  output logic                push,
  output htfd_pkg::frame_rec_t push_rec
);
  import htfd_pkg::*;

  pos_t              pos, pos_next, cur;
  logic [BYTE_W-1:0] crc, crc_next, crc_cur;
  logic [WORD_W-1:0] temp_word, temp_word_next;
  logic              temp_good, temp_good_next;
  logic [BYTE_W-1:0] hum_high, hum_high_next;
  logic [BYTE_W-1:0] hum_low, hum_low_next;
  logic              accept;

  assign byte_in.ready = !queue_full;
  assign accept        = byte_in.valid && byte_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_TEMP_HI;
      crc <= CRC_INIT;
    end else begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  always_ff @(posedge clk) begin
    temp_word <= temp_word_next;
    temp_good <= temp_good_next;
    hum_high  <= hum_high_next;
    hum_low   <= hum_low_next;
  end

  always_comb begin
    pos_next       = pos;
    crc_next       = crc;
    temp_word_next = temp_word;
    temp_good_next = temp_good;
    hum_high_next  = hum_high;
    hum_low_next   = hum_low;
    push           = 1'b0;
    push_rec       = '{temp_raw: temp_word, hum_raw: {hum_high, hum_low},
                       temp_crc_ok: temp_good, hum_crc_ok: (crc == byte_in.data_byte)};
    cur            = byte_in.frame_start ? POS_TEMP_HI : pos;
    crc_cur        = byte_in.frame_start ? CRC_INIT : crc;
    if (accept) begin
      case (cur)
        POS_TEMP_LO: begin
          crc_next       = crc8_feed(crc_cur, byte_in.data_byte);
          temp_word_next = {temp_word[WORD_W-1:BYTE_W], byte_in.data_byte};
          pos_next       = POS_TEMP_CRC;
        end
        POS_TEMP_CRC: begin
          temp_good_next = (crc_cur == byte_in.data_byte);
          crc_next       = CRC_INIT;
          pos_next       = POS_HUM_HI;
        end
        POS_HUM_HI: begin
          crc_next      = crc8_feed(crc_cur, byte_in.data_byte);
          hum_high_next = byte_in.data_byte;
          pos_next      = POS_HUM_LO;
        end
        POS_HUM_LO: begin
          crc_next     = crc8_feed(crc_cur, byte_in.data_byte);
          hum_low_next = byte_in.data_byte;
          pos_next     = POS_HUM_CRC;
        end
        POS_HUM_CRC: begin
          push     = 1'b1;
          crc_next = CRC_INIT;
          pos_next = POS_TEMP_HI;
        end
        default: begin
          // first byte, also any stray position code
          crc_next       = crc8_feed(CRC_INIT, byte_in.data_byte);
          temp_word_next = {byte_in.data_byte, {BYTE_W{1'b0}}};
          pos_next       = POS_TEMP_LO;
        end
      endcase
    end
  end

endmodule

// File: rtl/htfd_queue.sv
// short record queue between front and back ends
// depends on htfd_pkg
module htfd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  htfd_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output htfd_pkg::frame_rec_t pop_rec,
  output logic                 full,
  output logic                 empty
);
  import htfd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  frame_rec_t       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_rec = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

endmodule

// File: rtl/htfd_back.sv
// back end: scales raw words, checks limits, picks status, holds result
// depends on htfd_pkg, htfd_channels
module htfd_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 queue_empty,
  input  htfd_pkg::frame_rec_t pop_rec,
  output logic                 pop,
  input  htfd_pkg::limits_t    limits,
  htfd_result_if.source        result_out
);
  import htfd_pkg::*;

  // multiply stage
  logic               s1_valid;
  logic [TPROD_W-1:0] s1_tprod;
  logic [HPROD_W-1:0] s1_hprod;
  logic               s1_temp_ok, s1_hum_ok;
  logic               s1_adv, s1_load;

  // result stage
  logic                     out_valid;
  logic [WORD_W-1:0]        tq, hq;
  logic signed [WORD_W-1:0] temp16;
  logic signed [TEMP_W-1:0] temp;
  status_t                  status_next;

  assign s1_adv  = s1_valid && (!out_valid || result_out.ready);
  assign s1_load = !s1_valid || s1_adv;
  assign pop     = s1_load && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= !queue_empty;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_tprod   <= TEMP_SCALE * TPROD_W'(pop_rec.temp_raw);
      s1_hprod   <= HUM_SCALE * HPROD_W'(pop_rec.hum_raw);
      s1_temp_ok <= pop_rec.temp_crc_ok;
      s1_hum_ok  <= pop_rec.hum_crc_ok;
    end
  end

  always_comb begin
    tq     = div_full_scale(s1_tprod);
    hq     = div_full_scale(TPROD_W'(s1_hprod));
    temp16 = $signed(tq) - TEMP_OFFSET;
    temp   = temp16[TEMP_W-1:0];
    if (!s1_temp_ok) begin
      status_next = STATUS_TEMP_CRC;
    end else if (!s1_hum_ok) begin
      status_next = STATUS_HUM_CRC;
    end else if (!(temp > limits.low && temp < limits.high)) begin
      status_next = STATUS_RANGE;
    end else begin
      status_next = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result_out.temperature_centi <= temp;
      result_out.humidity_centi    <= hq[HUM_W-1:0];
      result_out.status            <= status_next;
    end
  end

  assign result_out.valid = out_valid;

endmodule

// File: rtl/humidity_temp_frame_decoder.sv
// top level of the humidity/temperature frame decoder: limit registers,
// front end, record queue, back end; depends on all rtl files but the checker
//
//   channel      dir  payload                                        accepted when
//   byte_in      in   data_byte[7:0], frame_start                    valid && ready
//   result_out   out  temperature_centi[14:0] s, humidity_centi[13:0],
//                     status[1:0]                                    valid && ready
//   cfg          in   reg_index[0], write_data[14:0]                 valid && ready
//
// one byte accepted per cycle while the record queue is not full; after its sixth
// byte a result passes the queue slot, the multiply stage and the result register
// byte_in stalls only when the record queue is full; the queue absorbs
// QUEUE_DEPTH complete replies while result_out is held off
// cfg is always ready; sync reset clears position, crc, queue and valids
module humidity_temp_frame_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic           clk,
  input  logic           rst,
  htfd_byte_if.sink      byte_in,
  htfd_result_if.source  result_out,
  htfd_cfg_if.sink       cfg
);
  import htfd_pkg::*;

  limits_t    limits;
  frame_rec_t push_rec, pop_rec;
  logic       push, pop, queue_full, queue_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.low  <= TEMP_LOW_RESET;
      limits.high <= TEMP_HIGH_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.reg_index)
        REG_TEMP_LOW:  limits.low  <= $signed(cfg.write_data);
        REG_TEMP_HIGH: limits.high <= $signed(cfg.write_data);
        default: ;
      endcase
    end
  end

  htfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .queue_full (queue_full),
    .push       (push),
    .push_rec   (push_rec)
  );

  htfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .full     (queue_full),
    .empty    (queue_empty)
  );

  htfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .pop_rec     (pop_rec),
    .pop         (pop),
    .limits      (limits),
    .result_out  (result_out)
  );

endmodule

// File: rtl/htfd_checker.sv
// port-level checks on the frame decoder result channel, bound to the top
// depends on htfd_pkg and humidity_temp_frame_decoder
module htfd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [htfd_pkg::TEMP_W-1:0] temperature_centi,
  input logic [htfd_pkg::HUM_W-1:0]         humidity_centi,
  input logic [htfd_pkg::STATUS_W-1:0]      status
);
  import htfd_pkg::*;

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(temperature_centi)
      && $stable(humidity_centi) && $stable(status))
    else $error("result changed while stalled");

  // scaling never leaves the sensor range
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> temperature_centi >= -15'sd4500 && temperature_centi <= 15'sd13000)
    else $error("temperature outside sensor range");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> humidity_centi <= 14'd10000)
    else $error("humidity above full scale");

  // no result right out of reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind humidity_temp_frame_decoder htfd_checker u_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (result_out.valid),
  .out_ready         (result_out.ready),
  .temperature_centi (result_out.temperature_centi),
  .humidity_centi    (result_out.humidity_centi),
  .status            (result_out.status)
);
